### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the nucleotide stream screen.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on aclk, off while aresetn is low.
`define NSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication form: antecedent |-> consequent.
`define NSS_ASSERT_IMPL(label, ante, cons, msg) \
    `NSS_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle form: antecedent |=> consequent.
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
    `NSS_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/nss_pkg.sv
// Package for the nucleotide stream screen: constants, character codes and shared types.
`default_nettype none

package nss_pkg;

    localparam int CHAR_W      = 8;
    localparam int STAT_W      = 17;
    localparam int MAX_LEN_DEF = 65536;

    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G    = 8'h47;
    localparam logic [CHAR_W-1:0] CH_N    = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_T    = 8'h54;
    localparam logic [CHAR_W-1:0] CH_U    = 8'h55;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Normalized character and its class.
    typedef struct packed {
        logic [CHAR_W-1:0] base;
        logic              acgt;
        logic              gap;
        logic              replaced;
    } norm_t;

    // Running statistics as presented on the result channel.
    typedef struct packed {
        logic [STAT_W-1:0] align_len;
        logic [STAT_W-1:0] base_count;
        logic [STAT_W-1:0] ambig_count;
        logic [STAT_W-1:0] replaced_count;
        logic [STAT_W-1:0] longest_run;
        logic [STAT_W-1:0] start_pos;
        logic [STAT_W-1:0] end_pos;
        logic              too_ambiguous;
    } stats_t;

endpackage

`default_nettype wire

### rtl/nss_normalize.sv
// Character normalizer: uppercase, optional U to T, invalid characters to N.
`default_nettype none

module nss_normalize (
    input  wire logic [nss_pkg::CHAR_W-1:0] char_in,
    input  wire logic                       convert_u,
    output nss_pkg::norm_t                  norm
);
    import nss_pkg::*;

    logic [CHAR_W-1:0] upper;
    logic [CHAR_W-1:0] conv;
    logic              acgt;
    logic              gap;
    logic              invalid;

    always_comb begin
        upper = char_in;
        if (char_in >= CH_LA && char_in <= CH_LZ) begin
            upper = char_in - CASE_OFFSET;
        end
        conv = upper;
        if (upper == CH_U && convert_u) begin
            conv = CH_T;
        end
        acgt    = (conv == CH_A) || (conv == CH_C) || (conv == CH_G) || (conv == CH_T);
        gap     = (conv == CH_DOT) || (conv == CH_DASH);
        invalid = !acgt && !gap && (conv != CH_N);

        norm.base     = invalid ? CH_N : conv;
        norm.acgt     = acgt;
        norm.gap      = gap;
        norm.replaced = invalid;
    end

endmodule

`default_nettype wire

### rtl/nss_stats.sv
// Running sequence statistics: saturating counters, homopolymer run and base positions.
`default_nettype none

module nss_stats #(
    parameter int MAX_LEN = nss_pkg::MAX_LEN_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic           last,
    input  wire nss_pkg::norm_t norm,
    output nss_pkg::stats_t     stats
);
    import nss_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0]  pos_reg,   pos_next;
    logic [CNT_W-1:0]  base_reg,  base_next;
    logic [CNT_W-1:0]  ambig_reg, ambig_next;
    logic [CNT_W-1:0]  rep_reg,   rep_next;
    logic [CNT_W-1:0]  run_reg,   run_next;
    logic [CNT_W-1:0]  best_reg,  best_next;
    logic [CNT_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  endp_reg,  endp_next;
    logic [CHAR_W-1:0] prev_reg,  prev_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + CNT_ONE;
    endfunction

    always_comb begin
        pos_next   = sat_inc(pos_reg);
        rep_next   = norm.replaced ? sat_inc(rep_reg) : rep_reg;
        base_next  = base_reg;
        ambig_next = ambig_reg;
        run_next   = run_reg;
        best_next  = best_reg;
        first_next = first_reg;
        endp_next  = endp_reg;
        prev_next  = prev_reg;
        if (!norm.gap) begin
            base_next = sat_inc(base_reg);
            if (first_reg == '0) begin
                first_next = pos_next;
            end
            endp_next = pos_next;
            if (!norm.acgt) begin
                ambig_next = sat_inc(ambig_reg);
            end
            run_next  = (prev_reg == norm.base) ? sat_inc(run_reg) : CNT_ONE;
            prev_next = norm.base;
            if (run_next > best_reg) begin
                best_next = run_next;
            end
        end

        stats.align_len      = STAT_W'(pos_next);
        stats.base_count     = STAT_W'(base_next);
        stats.ambig_count    = STAT_W'(ambig_next);
        stats.replaced_count = STAT_W'(rep_next);
        stats.longest_run    = STAT_W'(best_next);
        stats.start_pos      = STAT_W'(first_next);
        stats.end_pos        = STAT_W'(endp_next);
        stats.too_ambiguous  = {rep_next, 2'b00} > {2'b00, base_next};
    end

    // A transaction marked last closes the sequence: state goes back to reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            pos_reg   <= '0;
            base_reg  <= '0;
            ambig_reg <= '0;
            rep_reg   <= '0;
            run_reg   <= '0;
            best_reg  <= CNT_ONE;
            first_reg <= '0;
            endp_reg  <= '0;
            prev_reg  <= '0;
        end else if (step) begin
            pos_reg   <= pos_next;
            base_reg  <= base_next;
            ambig_reg <= ambig_next;
            rep_reg   <= rep_next;
            run_reg   <= run_next;
            best_reg  <= best_next;
            first_reg <= first_next;
            endp_reg  <= endp_next;
            prev_reg  <= prev_next;
        end
    end

`include "assert_macros.svh"

    `NSS_ASSERT_NEXT(a_clear_on_last, step && last, pos_reg == '0, "position not cleared")
    `NSS_ASSERT(a_best_nonzero, best_reg != '0, "longest run dropped to zero")
    `NSS_ASSERT(a_base_le_pos, base_reg <= pos_reg, "base count exceeds alignment length")
    `NSS_ASSERT_IMPL(a_no_base_no_start, base_reg == '0, first_reg == '0 && endp_reg == '0,
                     "position set without a base")

endmodule

`default_nettype wire

### rtl/nucleotide_stream_screen_top.sv
// Usage: s_ channel carries one ASCII character per transaction, s_last on the final one.
// The m_ channel returns one transaction per input: the normalized character and the
// running statistics of the sequence including that character; m_done_res echoes s_last
// and after it the statistics start over for the next sequence.
// cfg_wr_en/cfg_wr_data write convert_u (reset 1) in the cycle it is high; write it
// only while no transaction is in flight.
// An accepted character sits in the input register; its result is loaded into the
// result register, and shown on m_, once that register is empty or m_ready is high.
// Throughput: one character per cycle while m_ready is high; the normalizer, counter
// updates and compare between the two registers are the whole per-character path.
// Stall: when m_ready is low and m_valid high the result register holds, an empty input
// register still takes one more character, and s_ready drops until m_ready returns.
// Reset: aresetn low (synchronous) empties both registers, clears all statistics
// and sets convert_u to 1. Counts saturate at MAX_LEN and are shown in 17 bits.
`default_nettype none

module nucleotide_stream_screen_top #(
    parameter int MAX_LEN = nss_pkg::MAX_LEN_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_data,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [nss_pkg::CHAR_W-1:0]  s_char_in,
    input  wire logic                        s_last,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic [nss_pkg::CHAR_W-1:0]  m_base_out,
    output      logic                        m_done_res,
    output      logic [nss_pkg::STAT_W-1:0]  m_align_len,
    output      logic [nss_pkg::STAT_W-1:0]  m_base_count,
    output      logic [nss_pkg::STAT_W-1:0]  m_ambig_count,
    output      logic [nss_pkg::STAT_W-1:0]  m_replaced_count,
    output      logic [nss_pkg::STAT_W-1:0]  m_longest_run,
    output      logic [nss_pkg::STAT_W-1:0]  m_start_pos,
    output      logic [nss_pkg::STAT_W-1:0]  m_end_pos,
    output      logic                        m_too_ambiguous
);
    import nss_pkg::*;

    logic              convert_u_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_base_reg;
    logic              out_done_reg;
    stats_t            out_stats_reg;
    logic              advance;
    norm_t             norm;
    stats_t            stats;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            convert_u_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            convert_u_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_last_reg <= s_last;
        end
    end

    nss_normalize u_normalize (
        .char_in   (in_char_reg),
        .convert_u (convert_u_reg),
        .norm      (norm)
    );

    nss_stats #(
        .MAX_LEN (MAX_LEN)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .last    (in_last_reg),
        .norm    (norm),
        .stats   (stats)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_base_reg  <= norm.base;
            out_done_reg  <= in_last_reg;
            out_stats_reg <= stats;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_base_out       = out_base_reg;
    assign m_done_res       = out_done_reg;
    assign m_align_len      = out_stats_reg.align_len;
    assign m_base_count     = out_stats_reg.base_count;
    assign m_ambig_count    = out_stats_reg.ambig_count;
    assign m_replaced_count = out_stats_reg.replaced_count;
    assign m_longest_run    = out_stats_reg.longest_run;
    assign m_start_pos      = out_stats_reg.start_pos;
    assign m_end_pos        = out_stats_reg.end_pos;
    assign m_too_ambiguous  = out_stats_reg.too_ambiguous;

`include "assert_macros.svh"

    `NSS_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, in_valid_reg, "accepted transaction lost")
    `NSS_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "result register not loaded")
    `NSS_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid, "result dropped while stalled")

endmodule

`default_nettype wire

### sim/nss_stats_checker.sv
// Checker for the nucleotide stream screen: predicts each result transaction and compares it.
`timescale 1ns / 1ps

module nss_stats_checker
    import nss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_in,
    input  logic              s_last,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [CHAR_W-1:0] m_base_out,
    input  logic              m_done_res,
    input  logic [STAT_W-1:0] m_align_len,
    input  logic [STAT_W-1:0] m_base_count,
    input  logic [STAT_W-1:0] m_ambig_count,
    input  logic [STAT_W-1:0] m_replaced_count,
    input  logic [STAT_W-1:0] m_longest_run,
    input  logic [STAT_W-1:0] m_start_pos,
    input  logic [STAT_W-1:0] m_end_pos,
    input  logic              m_too_ambiguous,
    output int                error_count,
    output int                pending_count
);

    localparam int MAX_LEN = MAX_LEN_DEF;

    typedef struct packed {
        logic [CHAR_W-1:0] base;
        logic              done;
        stats_t            stats;
    } screen_result_t;

    screen_result_t screen_results_q[$];

    // shadow of the block's register and per-sequence counters
    logic              convert_u_q;
    logic [STAT_W-1:0] pos_cnt;
    logic [STAT_W-1:0] base_tot;
    logic [STAT_W-1:0] nonacgt_tot;
    logic [STAT_W-1:0] replaced_tot;
    logic [STAT_W-1:0] run_len;
    logic [STAT_W-1:0] best_run;
    logic [CHAR_W-1:0] prev_base;
    logic [STAT_W-1:0] first_pos;
    logic [STAT_W-1:0] last_pos;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        return (v >= MAX_LEN) ? STAT_W'(MAX_LEN) : v + 1'b1;
    endfunction

    function automatic void clear_counts();
        pos_cnt      = '0;
        base_tot     = '0;
        nonacgt_tot  = '0;
        replaced_tot = '0;
        run_len      = '0;
        best_run     = STAT_W'(1);
        prev_base    = '0;
        first_pos    = '0;
        last_pos     = '0;
    endfunction

    // Normalize one character, update the running statistics, return the expected result.
    function automatic screen_result_t screen_step(input logic [CHAR_W-1:0] ch_in,
                                                   input logic fin);
        screen_result_t r;
        logic [CHAR_W-1:0] c;
        logic is_acgt;
        logic is_gap;
        c = ch_in;
        if (c >= CH_LA && c <= CH_LZ) begin
            c = c - CASE_OFFSET;
        end
        if (c == CH_U && convert_u_q) begin
            c = CH_T;
        end
        is_acgt = (c == CH_A) || (c == CH_C) || (c == CH_G) || (c == CH_T);
        is_gap  = (c == CH_DOT) || (c == CH_DASH);
        if (!is_acgt && !is_gap && c != CH_N) begin
            c = CH_N;
            replaced_tot = sat_inc(replaced_tot);
        end
        pos_cnt = sat_inc(pos_cnt);
        if (!is_gap) begin
            base_tot = sat_inc(base_tot);
            if (first_pos == '0) begin
                first_pos = pos_cnt;
            end
            last_pos = pos_cnt;
            if (!is_acgt) begin
                nonacgt_tot = sat_inc(nonacgt_tot);
            end
            // gaps leave prev_base alone, so a run continues across them
            run_len   = (prev_base == c) ? sat_inc(run_len) : STAT_W'(1);
            prev_base = c;
            if (run_len > best_run) begin
                best_run = run_len;
            end
        end
        r.base                 = c;
        r.done                 = fin;
        r.stats.align_len      = pos_cnt;
        r.stats.base_count     = base_tot;
        r.stats.ambig_count    = nonacgt_tot;
        r.stats.replaced_count = replaced_tot;
        r.stats.longest_run    = best_run;
        r.stats.start_pos      = first_pos;
        r.stats.end_pos        = last_pos;
        r.stats.too_ambiguous  = ({replaced_tot, 2'b00} > {2'b00, base_tot});
        if (fin) begin
            clear_counts();
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                               input logic [STAT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        screen_result_t want;
        if (!aresetn) begin
            convert_u_q = 1'b1;
            clear_counts();
            screen_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (screen_results_q.size() == 0) begin
                    $error("result transaction with no input pending");
                    error_count++;
                end else begin
                    want = screen_results_q.pop_front();
                    check_field("base_out", want.base, m_base_out);
                    check_field("done_res", want.done, m_done_res);
                    check_field("align_len", want.stats.align_len, m_align_len);
                    check_field("base_count", want.stats.base_count, m_base_count);
                    check_field("ambig_count", want.stats.ambig_count, m_ambig_count);
                    check_field("replaced_count", want.stats.replaced_count,
                                m_replaced_count);
                    check_field("longest_run", want.stats.longest_run, m_longest_run);
                    check_field("start_pos", want.stats.start_pos, m_start_pos);
                    check_field("end_pos", want.stats.end_pos, m_end_pos);
                    check_field("too_ambiguous", want.stats.too_ambiguous,
                                m_too_ambiguous);
                end
            end
            if (s_valid && s_ready) begin
                screen_results_q.insert(screen_results_q.size(),
                                        screen_step(s_char_in, s_last));
            end
            // writes only happen while idle, so the order against inputs does not matter
            if (cfg_wr_en) begin
                convert_u_q = cfg_wr_data;
            end
        end
        pending_count = screen_results_q.size();
    end

endmodule

### sim/nucleotide_stream_screen_top_test.sv
// Testbench top for the nucleotide stream screen: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module nucleotide_stream_screen_top_test;
    import nss_pkg::*;

    localparam int RANDOM_ITEMS = 1750;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic              cfg_wr_data = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_char_in   = '0;
    logic              s_last      = 1'b0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [CHAR_W-1:0] m_base_out;
    logic              m_done_res;
    logic [STAT_W-1:0] m_align_len;
    logic [STAT_W-1:0] m_base_count;
    logic [STAT_W-1:0] m_ambig_count;
    logic [STAT_W-1:0] m_replaced_count;
    logic [STAT_W-1:0] m_longest_run;
    logic [STAT_W-1:0] m_start_pos;
    logic [STAT_W-1:0] m_end_pos;
    logic              m_too_ambiguous;

    int   error_count;
    int   pending_count;
    int   send_idle_pct = 26;
    int   recv_idle_pct = 76;
    logic hold_req      = 1'b0;

    nucleotide_stream_screen_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_in        (s_char_in),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_base_out       (m_base_out),
        .m_done_res       (m_done_res),
        .m_align_len      (m_align_len),
        .m_base_count     (m_base_count),
        .m_ambig_count    (m_ambig_count),
        .m_replaced_count (m_replaced_count),
        .m_longest_run    (m_longest_run),
        .m_start_pos      (m_start_pos),
        .m_end_pos        (m_end_pos),
        .m_too_ambiguous  (m_too_ambiguous)
    );

    nss_stats_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_in        (s_char_in),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_base_out       (m_base_out),
        .m_done_res       (m_done_res),
        .m_align_len      (m_align_len),
        .m_base_count     (m_base_count),
        .m_ambig_count    (m_ambig_count),
        .m_replaced_count (m_replaced_count),
        .m_longest_run    (m_longest_run),
        .m_start_pos      (m_start_pos),
        .m_end_pos        (m_end_pos),
        .m_too_ambiguous  (m_too_ambiguous),
        .error_count      (error_count),
        .pending_count    (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("nucleotide_stream_screen_top test failed");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                for (int h = 0; h < 64; h++) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_char_in <= ch;
        s_last    <= fin;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_convert_u(input logic v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_string(input string txt, input logic close_seq);
        for (int k = 0; k < txt.len(); k++) begin
            offer_char(txt[k], close_seq && (k == txt.len() - 1));
        end
    endtask

    // Biased toward repeats and valid letters so homopolymer runs get long.
    function automatic logic [CHAR_W-1:0] pick_char(input logic [CHAR_W-1:0] prev);
        string alpha = "ACGTNacgtnuU";
        int    r     = $urandom_range(99);
        if (r < 30) return prev;
        if (r < 78) return alpha[$urandom_range(alpha.len() - 1)];
        if (r < 90) return $urandom_range(1) ? CH_DASH : CH_DOT;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic send_random_sequences(input int n_items);
        int                sent;
        int                len;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        ch   = CH_A;
        while (sent < n_items) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 30);
            for (int k = 0; k < len; k++) begin
                ch = pick_char(ch);
                offer_char(ch, k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [CHAR_W-1:0] odd_bytes[$];
        odd_bytes = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'h80, 8'hFF};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: gap-only sequence, then case folding, U, runs across gaps, invalid bytes
        send_string("-.", 1'b1);
        send_string("aA-AcgtuUnNz#", 1'b0);
        foreach (odd_bytes[i]) begin
            offer_char(odd_bytes[i], i == odd_bytes.size() - 1);
        end
        drain_results();
        write_convert_u(1'b0);
        send_string("uU", 1'b1);
        drain_results();

        write_convert_u(1'b1);
        send_random_sequences(RANDOM_ITEMS / 3);
        drain_results();

        send_idle_pct = 76;
        recv_idle_pct = 26;
        write_convert_u(1'b0);
        send_random_sequences(RANDOM_ITEMS / 3);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_convert_u(1'b1);
        hold_req = 1'b1;
        send_random_sequences(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_results();

        if (error_count == 0) begin
            $display("nucleotide_stream_screen_top test passed");
        end else begin
            $display("nucleotide_stream_screen_top test failed");
        end
        $finish;
    end

endmodule
